// ===== rtl/swd_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the sinc evaluator.
package swd_pkg;

  localparam int DATA_WIDTH_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 30;

  localparam int          THR_W     = 24;
  localparam logic [23:0] THR_RESET = 24'd1677722;   // 0.1 in Q0.24

  localparam int XW = 32;   // argument after clamping, Q7.24
  localparam int AW = 31;   // reduced angle, Q.30
  localparam int PW = 31;   // magnitude of a Taylor power, Q.30
  localparam int CW = 34;   // CORDIC vector components
  localparam int ZW = 33;   // CORDIC residual angle
  localparam int VW = 64;   // internal result width

  localparam logic [31:0]        TWO_OVER_PI = 32'd2734261102;
  localparam logic [30:0]        HALF_PI     = 31'd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [VW-1:0] Q30_ONE = 64'sd1073741824;
  localparam logic signed [VW-1:0] THIRD   = 64'sd357913941;   // round(2^30 / 3)

  // Taylor terms: power of x and integer denominator
  localparam int NTERM = 13;
  localparam int TERM_POW [NTERM] = '{2, 4, 6, 8, 1, 3, 5, 7, 9, 2, 4, 6, 8};
  localparam int TERM_DIV [NTERM] = '{6, 120, 5040, 362880,
                                      3, 30, 840, 45360, 3991680,
                                      10, 168, 6480, 443520};

  // Division by the argument: 2^24 scale, quotient limited to 2^60
  localparam int             DIV_SCALE   = 24;
  localparam int             DIV_QBITS   = 61;
  localparam logic [60:0]    INNER_LIMIT = 61'h1000_0000_0000_0000;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic                 taylor;
    logic [1:0]           quad;
    logic [AW-1:0]        ang;
  } swd_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic                 taylor;
    logic signed [VW-1:0] tsv;
    logic signed [VW-1:0] td1;
    logic signed [VW-1:0] td2;
  } swd_side_t;

  typedef struct packed {
    swd_side_t            base;
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] sv;
    logic signed [VW-1:0] d1;
  } swd_dside_t;

  function automatic logic [31:0] cordic_atan(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      default: begin
        if (i <= 30) v = 32'd1 << (30 - i);
        else v = 32'd0;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/swd_front.sv =====
// Front end: argument transfer, clamping, path choice and quadrant reduction.
module swd_front #(
  parameter int DATA_WIDTH = swd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swd_pkg::THR_W-1:0]    cfg_data,
  output logic                         q_valid,
  input  logic                         q_ready,
  output swd_pkg::swd_item_t           q_item
);
  import swd_pkg::*;

  logic [THR_W-1:0]     thr_r;
  logic                 fen;
  logic signed [63:0]   x_ext;
  logic signed [XW-1:0] x_nxt;
  logic [XW-1:0]        ax_nxt;
  logic                 tay_nxt;

  logic                 f1_vld_r, f2_vld_r;
  logic signed [XW-1:0] f1_x_r, f2_x_r;
  logic [XW-1:0]        f1_ax_r;
  logic                 f1_tay_r, f2_tay_r;
  logic [63:0]          turns;
  logic [31:0]          f2_t_r;
  logic [60:0]          ang_prod;

  assign x_ext = 64'(in_x_value);

  always_comb begin
    priority if (x_ext > 64'sd2147483647) x_nxt = 32'sh7fffffff;
    else if (x_ext < -64'sd2147483648)    x_nxt = 32'sh80000000;
    else                                  x_nxt = x_ext[XW-1:0];
  end

  assign ax_nxt  = x_nxt[XW-1] ? 32'(-x_nxt) : 32'(x_nxt);
  assign tay_nxt = (ax_nxt < {{(XW-THR_W){1'b0}}, thr_r}) || (x_nxt == '0);

  // hold everything while the last stage waits on a full queue
  assign fen       = !f2_vld_r || q_ready;
  assign in_ready  = fen;
  assign cfg_ready = 1'b1;

  assign turns = 64'(f1_ax_r) * 64'(TWO_OVER_PI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) thr_r <= cfg_data;
      if (fen) begin
        f1_vld_r <= in_valid;
        f2_vld_r <= f1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_x_r   <= x_nxt;
      f1_ax_r  <= ax_nxt;
      f1_tay_r <= tay_nxt;
      f2_x_r   <= f1_x_r;
      f2_tay_r <= f1_tay_r;
      f2_t_r   <= turns[57:26];
    end
  end

  assign ang_prod = 61'(f2_t_r[29:0]) * 61'(HALF_PI) + 61'(32'd536870912);

  assign q_valid       = f2_vld_r;
  assign q_item.x      = f2_x_r;
  assign q_item.taylor = f2_tay_r;
  assign q_item.quad   = f2_t_r[31:30];
  assign q_item.ang    = ang_prod[60:30];

endmodule

// ===== rtl/swd_queue.sv =====
// Short item queue between the front end and the evaluation pipeline.
module swd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  swd_pkg::swd_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output swd_pkg::swd_item_t pop_item
);
  import swd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  swd_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== rtl/swd_div.sv =====
// Pipelined restoring divider: round(num * 2^24 / den), magnitude limited to 2^60.
module swd_div #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [swd_pkg::VW-1:0] in_num,
  input  logic signed [swd_pkg::XW-1:0] in_den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic signed [swd_pkg::VW-1:0] out_quot,
  output logic [SIDE_W-1:0]             out_side
);
  import swd_pkg::*;

  localparam int QB   = DIV_QBITS;
  localparam int NN_W = VW + DIV_SCALE;
  localparam int HI_W = NN_W - QB;

  logic [VW-1:0]   un;
  logic [XW-1:0]   ud;
  logic [NN_W-1:0] nn;

  logic              v_r   [0:QB];
  logic [XW-1:0]     rem_r [0:QB];
  logic [QB-1:0]     lo_r  [0:QB];
  logic [QB-1:0]     q_r   [0:QB];
  logic [XW-1:0]     ud_r  [0:QB];
  logic              neg_r [0:QB];
  logic              ovf_r [0:QB];
  logic [SIDE_W-1:0] side_r [0:QB];

  logic                 o_vld_r;
  logic signed [VW-1:0] o_quot_r;
  logic [SIDE_W-1:0]    o_side_r;
  logic [QB-1:0]        mag;

  assign un = in_num[VW-1] ? VW'(-in_num) : VW'(in_num);
  assign ud = in_den[XW-1] ? XW'(-in_den) : XW'(in_den);
  assign nn = {un, {DIV_SCALE{1'b0}}} + NN_W'(ud >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= XW'(nn[NN_W-1:QB]);
      lo_r[0]   <= nn[QB-1:0];
      q_r[0]    <= '0;
      ud_r[0]   <= ud;
      neg_r[0]  <= in_num[VW-1] ^ in_den[XW-1];
      ovf_r[0]  <= XW'(nn[NN_W-1:QB]) >= ud;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [XW:0] r2, diff;
    logic        ge;

    assign r2   = {rem_r[k-1], lo_r[k-1][QB-1]};
    assign diff = r2 - {1'b0, ud_r[k-1]};
    assign ge   = r2 >= {1'b0, ud_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[XW-1:0] : r2[XW-1:0];
        lo_r[k]   <= {lo_r[k-1][QB-2:0], 1'b0};
        q_r[k]    <= {q_r[k-1][QB-2:0], ge};
        ud_r[k]   <= ud_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign mag = (ovf_r[QB] || (q_r[QB] > INNER_LIMIT)) ? INNER_LIMIT : q_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= v_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_quot_r <= neg_r[QB] ? -$signed(VW'(mag)) : $signed(VW'(mag));
      o_side_r <= side_r[QB];
    end
  end

  assign out_valid = o_vld_r;
  assign out_quot  = o_quot_r;
  assign out_side  = o_side_r;

endmodule

// ===== rtl/swd_back.sv =====
// Evaluation pipeline: Taylor series, CORDIC, three divisions and output saturation.
module swd_back #(
  parameter int DATA_WIDTH   = swd_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = swd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  swd_pkg::swd_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_sinc_value,
  output logic signed [DATA_WIDTH-1:0] out_first_derivative,
  output logic signed [DATA_WIDTH-1:0] out_second_derivative
);
  import swd_pkg::*;

  localparam int S = CORDIC_STEPS;
  localparam int DSW = $bits(swd_dside_t);
  localparam logic signed [VW-1:0] OUT_HI = (64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1;
  localparam logic signed [VW-1:0] OUT_LO = -OUT_HI - 64'sd1;

  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    priority if (v > OUT_HI) c = OUT_HI;
    else if (v < OUT_LO)     c = OUT_LO;
    else                     c = v;
    return DATA_WIDTH'(c);
  endfunction

  logic en;
  logic out_vld_r;
  logic signed [DATA_WIDTH-1:0] o_sv_r, o_d1_r, o_d2_r;

  // whole pipeline advances together; the output register parts it from the sink
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // ---------------- Taylor powers ----------------
  logic          tv_r  [0:8];
  swd_item_t     ti_r  [0:8];
  logic [PW-1:0] pw_r  [0:8][1:9];
  logic [XW-1:0] xmag;
  logic [PW-1:0] m1;

  assign xmag = in_item.x[XW-1] ? XW'(-in_item.x) : XW'(in_item.x);
  assign m1   = PW'({xmag[23:0], 6'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) tv_r[0] <= 1'b0;
    else if (en) tv_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ti_r[0] <= in_item;
      for (int k = 1; k <= 9; k++) pw_r[0][k] <= m1;
    end
  end

  for (genvar j = 1; j <= 8; j++) begin : g_pow
    logic [2*PW-1:0] prod;
    logic [2*PW-1:0] rnd;

    assign prod = (2*PW)'(pw_r[j-1][j]) * (2*PW)'(pw_r[j-1][1]);
    assign rnd  = prod + (2*PW)'(32'd536870912);

    always_ff @(posedge clk) begin
      if (!rst_n) tv_r[j] <= 1'b0;
      else if (en) tv_r[j] <= tv_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ti_r[j] <= ti_r[j-1];
        for (int k = 1; k <= 9; k++)
          pw_r[j][k] <= (k == j + 1) ? rnd[PW+29:30] : pw_r[j-1][k];
      end
    end
  end

  // ---------------- Taylor terms: division by constants ----------------
  logic        dv1_r, dv2_r;
  swd_item_t   di1_r, di2_r;
  logic [31:0] tn_r [NTERM];
  logic [31:0] tq_r [NTERM];
  logic [31:0] tc_r [NTERM];

  for (genvar t = 0; t < NTERM; t++) begin : g_term
    localparam int          P   = TERM_POW[t];
    localparam logic [31:0] D   = 32'(TERM_DIV[t]);
    localparam logic [31:0] RCP = 32'((64'd1 << 32) / 64'(TERM_DIV[t]));
    logic [31:0] n;
    logic [63:0] est;
    logic [31:0] r;

    assign n   = 32'(pw_r[8][P]) + (D >> 1);
    assign est = 64'(n) * 64'(RCP);
    assign r   = tn_r[t] - 32'(64'(tq_r[t]) * 64'(D));

    // reciprocal estimate is at most one short: one correction step
    always_ff @(posedge clk) begin
      if (en) begin
        tn_r[t] <= n;
        tq_r[t] <= est[63:32];
        tc_r[t] <= (r >= D) ? tq_r[t] + 32'd1 : tq_r[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv1_r <= 1'b0;
      dv2_r <= 1'b0;
    end else if (en) begin
      dv1_r <= tv_r[8];
      dv2_r <= dv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      di1_r <= ti_r[8];
      di2_r <= di1_r;
    end
  end

  // ---------------- Taylor sums ----------------
  logic signed [VW-1:0] tq [NTERM];
  logic signed [VW-1:0] t_sv, t_odd, t_d1, t_d2;

  always_comb begin
    for (int t = 0; t < NTERM; t++) tq[t] = $signed({32'd0, tc_r[t]});
    t_sv  = Q30_ONE - tq[0] + tq[1] - tq[2] + tq[3];
    t_odd = -tq[4] + tq[5] - tq[6] + tq[7] - tq[8];
    t_d1  = di2_r.x[XW-1] ? -t_odd : t_odd;
    t_d2  = -THIRD + tq[9] - tq[10] + tq[11] - tq[12];
  end

  logic          ts_vld_r;
  swd_side_t     ts_side_r;
  logic [1:0]    ts_quad_r;
  logic [AW-1:0] ts_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ts_vld_r <= 1'b0;
    else if (en) ts_vld_r <= dv2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts_side_r.x      <= di2_r.x;
      ts_side_r.taylor <= di2_r.taylor;
      ts_side_r.tsv    <= t_sv;
      ts_side_r.td1    <= t_d1;
      ts_side_r.td2    <= t_d2;
      ts_quad_r        <= di2_r.quad;
      ts_ang_r         <= di2_r.ang;
    end
  end

  // ---------------- CORDIC rotation ----------------
  logic                 cv_r [0:S];
  logic signed [CW-1:0] cx_r [0:S];
  logic signed [CW-1:0] cy_r [0:S];
  logic signed [ZW-1:0] cz_r [0:S];
  swd_side_t            cs_r [0:S];
  logic [1:0]           cq_r [0:S];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= ts_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= $signed(ZW'(ts_ang_r));
      cs_r[0] <= ts_side_r;
      cq_r[0] <= ts_quad_r;
    end
  end

  for (genvar i = 1; i <= S; i++) begin : g_rot
    localparam int SH = i - 1;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;

    assign dx = cy_r[i-1] >>> SH;
    assign dy = cx_r[i-1] >>> SH;
    assign at = $signed({1'b0, cordic_atan(SH)});

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i] <= 1'b0;
      else if (en) cv_r[i] <= cv_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cz_r[i-1] >= 0) begin
          cx_r[i] <= cx_r[i-1] - dx;
          cy_r[i] <= cy_r[i-1] + dy;
          cz_r[i] <= cz_r[i-1] - at;
        end else begin
          cx_r[i] <= cx_r[i-1] + dx;
          cy_r[i] <= cy_r[i-1] - dy;
          cz_r[i] <= cz_r[i-1] + at;
        end
        cs_r[i] <= cs_r[i-1];
        cq_r[i] <= cq_r[i-1];
      end
    end
  end

  // ---------------- quadrant mapping ----------------
  logic signed [VW-1:0] fx, fy, s_nxt, c_nxt;
  logic                 mv_r;
  logic signed [VW-1:0] ms_r, mc_r;
  swd_side_t            mside_r;

  assign fx = VW'(cx_r[S]);
  assign fy = VW'(cy_r[S]);

  always_comb begin
    unique case (cq_r[S])
      2'd0: begin s_nxt = fy;  c_nxt = fx;  end
      2'd1: begin s_nxt = fx;  c_nxt = -fy; end
      2'd2: begin s_nxt = -fy; c_nxt = -fx; end
      default: begin s_nxt = -fx; c_nxt = fy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (en) mv_r <= cv_r[S];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms_r    <= cs_r[S].x[XW-1] ? -s_nxt : s_nxt;
      mc_r    <= c_nxt;
      mside_r <= cs_r[S];
    end
  end

  // ---------------- three divisions by x ----------------
  swd_dside_t           ds0, ds1, ds2, ds3, ds_in2, ds_in3;
  logic                 dv1, dv2, dv3;
  logic signed [VW-1:0] dq1, dq2, dq3, num2, num3;

  always_comb begin
    ds0      = '{base: mside_r, c: mc_r, sv: '0, d1: '0};
    ds_in2    = ds1;
    ds_in2.sv = dq1;
    num2      = ds1.c - dq1;
    ds_in3    = ds2;
    ds_in3.d1 = dq2;
    num3      = dq2 <<< 1;
  end

  swd_div #(.SIDE_W(DSW)) u_div_sinc (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(mv_r), .in_num(ms_r), .in_den(mside_r.x), .in_side(ds0),
    .out_valid(dv1), .out_quot(dq1), .out_side(ds1)
  );

  swd_div #(.SIDE_W(DSW)) u_div_first (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dv1), .in_num(num2), .in_den(ds1.base.x), .in_side(ds_in2),
    .out_valid(dv2), .out_quot(dq2), .out_side(ds2)
  );

  swd_div #(.SIDE_W(DSW)) u_div_second (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dv2), .in_num(num3), .in_den(ds2.base.x), .in_side(ds_in3),
    .out_valid(dv3), .out_quot(dq3), .out_side(ds3)
  );

  // ---------------- result selection and saturation ----------------
  logic signed [VW-1:0] r_sv, r_d1, r_d2;

  always_comb begin
    if (ds3.base.taylor) begin
      r_sv = ds3.base.tsv;
      r_d1 = ds3.base.td1;
      r_d2 = ds3.base.td2;
    end else begin
      r_sv = ds3.sv;
      r_d1 = ds3.d1;
      r_d2 = -ds3.sv - dq3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_sv_r <= sat(r_sv);
      o_d1_r <= sat(r_d1);
      o_d2_r <= sat(r_d2);
    end
  end

  assign out_valid             = out_vld_r;
  assign out_sinc_value        = o_sv_r;
  assign out_first_derivative  = o_d1_r;
  assign out_second_derivative = o_d2_r;

endmodule

// ===== rtl/sinc_with_derivatives_core.sv =====
// Top level of the sinc evaluator: sinc(x), its first and second derivative.
// Most of the pipeline depth lies in the three 63-stage dividers and the CORDIC pipeline.
// Throughput: one argument per cycle; a stalled result holds the whole back pipeline,
// and the four-entry queue absorbs the front end meanwhile.
// Reset (rst_n low, synchronous) empties all stages and sets the threshold to 0.1.
module sinc_with_derivatives_core #(
  parameter int DATA_WIDTH   = swd_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = swd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swd_pkg::THR_W-1:0]    cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_sinc_value,
  output logic signed [DATA_WIDTH-1:0] out_first_derivative,
  output logic signed [DATA_WIDTH-1:0] out_second_derivative
);
  import swd_pkg::*;

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  swd_item_t fq_item, qb_item;

  swd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_x_value(in_x_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  swd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_item(fq_item),
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_item(qb_item)
  );

  swd_back #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(qb_valid), .in_ready(qb_ready), .in_item(qb_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sinc_value(out_sinc_value),
    .out_first_derivative(out_first_derivative),
    .out_second_derivative(out_second_derivative)
  );

endmodule

// ===== rtl/swd_checker.sv =====
// Port-level checks for the sinc evaluator, bound to the top level.
module swd_checker #(
  parameter int DATA_WIDTH = swd_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [DATA_WIDTH-1:0] in_x_value,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [swd_pkg::THR_W-1:0]    cfg_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_sinc_value,
  input logic signed [DATA_WIDTH-1:0] out_first_derivative,
  input logic signed [DATA_WIDTH-1:0] out_second_derivative
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sinc_value)
      && $stable(out_first_derivative) && $stable(out_second_derivative))
    else $error("result changed while stalled");

  // reset drains the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty front end takes an argument right after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // a result never appears straight out of reset
  a_no_rise_in_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n))
    else $error("result rose during reset");

  // threshold writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("threshold write refused");

endmodule

bind sinc_with_derivatives_core swd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_swd_checker (.*);
